// File: rtl/stepper_phase_sequencer_top_assert.svh
// Assertion macros for the stepper phase sequencer.
// Used by the sequencer core; no other dependencies.
`ifndef STEPPER_PHASE_SEQUENCER_TOP_ASSERT_SVH
`define STEPPER_PHASE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SPS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sps_pkg.sv
// Shared types, constants and the coil phase table for the stepper phase sequencer.
// No dependencies.
`timescale 1ns / 1ps

package sps_pkg;

   localparam int STEP_COUNT_WIDTH = 16;
   localparam int INTERVAL_WIDTH   = 24;
   localparam int STEP_TOTAL_WIDTH = 32;
   localparam int PHASE_WIDTH      = 3;
   localparam int COIL_WIDTH       = 4;
   localparam int CSR_INDEX_WIDTH  = 1;

   localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = INTERVAL_WIDTH'(1000);

   typedef enum logic [1:0] {
      OP_TICK        = 2'd0,
      OP_LOAD_MOVE   = 2'd1,
      OP_SET_DIR     = 2'd2,
      OP_CLEAR_COUNT = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_STEP_INTERVAL = 1'd0,
      CSR_HALF_STEP     = 1'd1
   } csr_index_type;

   typedef struct packed {
      op_type                      operation;
      logic                        zero_switch_pressed;
      logic                        end_switch_pressed;
      logic [STEP_COUNT_WIDTH-1:0] move_steps;
      logic                        move_left;
   } req_type;

   typedef struct packed {
      logic [COIL_WIDTH-1:0]       coil_pattern;
      logic                        at_zero;
      logic                        at_end;
      logic [STEP_COUNT_WIDTH-1:0] steps_left;
      logic [STEP_TOTAL_WIDTH-1:0] step_total;
   } rsp_type;

   typedef struct packed {
      logic [INTERVAL_WIDTH-1:0] step_interval_ticks;
      logic                      half_step_mode;
   } cfg_type;

   // Half-step coil table, phases zero through seven
   function automatic logic [COIL_WIDTH-1:0] coil_for_phase(input logic [PHASE_WIDTH-1:0] phase);
      logic [COIL_WIDTH-1:0] coils;
      case (phase)
         3'd0:    coils = 4'd4;
         3'd1:    coils = 4'd6;
         3'd2:    coils = 4'd2;
         3'd3:    coils = 4'd10;
         3'd4:    coils = 4'd8;
         3'd5:    coils = 4'd9;
         3'd6:    coils = 4'd1;
         default: coils = 4'd5;
      endcase
      return coils;
   endfunction

endpackage

// File: rtl/sps_core.sv
// Sequencer state and single-pass update for one request per cycle while advance is high.
// Depends on sps_pkg and stepper_phase_sequencer_top_assert.svh.
`timescale 1ns / 1ps

`include "stepper_phase_sequencer_top_assert.svh"

module sps_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  sps_pkg::req_type req,
   input  sps_pkg::cfg_type cfg,
   output sps_pkg::rsp_type result
);

   logic [sps_pkg::PHASE_WIDTH-1:0]      phase_ff, phase_in;
   logic [sps_pkg::STEP_COUNT_WIDTH-1:0] remaining_ff, remaining_in;
   logic [sps_pkg::STEP_TOTAL_WIDTH-1:0] step_count_ff, step_count_in;
   logic                                 dir_left_ff, dir_left_in;
   logic [sps_pkg::INTERVAL_WIDTH-1:0]   elapsed_ff, elapsed_in;
   logic                                 zero_armed_ff, zero_armed_in;
   logic                                 end_armed_ff, end_armed_in;
   logic                                 zero_seen_ff, zero_seen_in;
   logic                                 end_seen_ff, end_seen_in;
   logic [sps_pkg::COIL_WIDTH-1:0]       coil_ff, coil_in;

   logic                                 cancel_zero;
   logic                                 cancel_end;
   logic [sps_pkg::STEP_COUNT_WIDTH-1:0] remaining_tick;
   logic [sps_pkg::INTERVAL_WIDTH-1:0]   elapsed_inc;
   logic [1:0]                           amount;
   logic [sps_pkg::PHASE_WIDTH-1:0]      phase_step;
   logic                                 step_due;

   // Tick datapath: switches first, then the interval counter, then a possible step
   always_comb begin
      cancel_zero    = req.zero_switch_pressed && zero_armed_ff && dir_left_ff;
      cancel_end     = req.end_switch_pressed && end_armed_ff && !dir_left_ff;
      remaining_tick = (cancel_zero || cancel_end) ? '0 : remaining_ff;
      elapsed_inc    = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
      amount         = cfg.half_step_mode ? 2'd1 : 2'd2;
      phase_step     = dir_left_ff ? phase_ff - sps_pkg::PHASE_WIDTH'(amount)
                                   : phase_ff + sps_pkg::PHASE_WIDTH'(amount);
      step_due       = (remaining_tick != '0) && (elapsed_inc >= cfg.step_interval_ticks);
   end

   always_comb begin
      phase_in      = phase_ff;
      remaining_in  = remaining_ff;
      step_count_in = step_count_ff;
      dir_left_in   = dir_left_ff;
      elapsed_in    = elapsed_ff;
      zero_armed_in = zero_armed_ff;
      end_armed_in  = end_armed_ff;
      zero_seen_in  = zero_seen_ff;
      end_seen_in   = end_seen_ff;
      coil_in       = coil_ff;
      unique case (req.operation)
         sps_pkg::OP_TICK: begin
            zero_seen_in  = req.zero_switch_pressed;
            end_seen_in   = req.end_switch_pressed;
            zero_armed_in = !req.zero_switch_pressed || (zero_armed_ff && !cancel_zero);
            end_armed_in  = !req.end_switch_pressed || (end_armed_ff && !cancel_end);
            remaining_in  = remaining_tick;
            elapsed_in    = elapsed_inc;
            if (step_due) begin
               phase_in      = phase_step;
               step_count_in = step_count_ff + sps_pkg::STEP_TOTAL_WIDTH'(amount);
               remaining_in  = (remaining_tick > sps_pkg::STEP_COUNT_WIDTH'(amount))
                             ? remaining_tick - sps_pkg::STEP_COUNT_WIDTH'(amount) : '0;
               elapsed_in    = '0;
            end
            // coils follow the phase only while a move is running
            if (remaining_tick != '0) begin
               coil_in = sps_pkg::coil_for_phase(phase_in);
            end else begin
               coil_in = '0;
            end
         end
         sps_pkg::OP_LOAD_MOVE: begin
            remaining_in = req.move_steps;
            dir_left_in  = req.move_left;
         end
         sps_pkg::OP_SET_DIR: begin
            dir_left_in = req.move_left;
         end
         sps_pkg::OP_CLEAR_COUNT: begin
            step_count_in = '0;
         end
      endcase
   end

   always_comb begin
      result.coil_pattern = coil_in;
      result.at_zero      = zero_seen_in;
      result.at_end       = end_seen_in;
      result.steps_left   = remaining_in;
      result.step_total   = step_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         remaining_ff  <= '0;
         step_count_ff <= '0;
         dir_left_ff   <= 1'b0;
         elapsed_ff    <= '0;
         zero_armed_ff <= 1'b1;
         end_armed_ff  <= 1'b1;
         zero_seen_ff  <= 1'b0;
         end_seen_ff   <= 1'b0;
         coil_ff       <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         remaining_ff  <= remaining_in;
         step_count_ff <= step_count_in;
         dir_left_ff   <= dir_left_in;
         elapsed_ff    <= elapsed_in;
         zero_armed_ff <= zero_armed_in;
         end_armed_ff  <= end_armed_in;
         zero_seen_ff  <= zero_seen_in;
         end_seen_ff   <= end_seen_in;
         coil_ff       <= coil_in;
      end
   end

   `SPS_ASSERT_NEXT(a_tick_count_step, clock, reset, advance && req.operation == sps_pkg::OP_TICK, (step_count_ff - $past(step_count_ff)) <= 32'd2, "step counter moved by more than two on a tick")
   `SPS_ASSERT_NEXT(a_tick_no_refill, clock, reset, advance && req.operation == sps_pkg::OP_TICK, remaining_ff <= $past(remaining_ff), "remaining steps grew on a tick")
   `SPS_ASSERT_IMPLIES(a_zero_disarm, clock, reset, !zero_armed_ff, zero_seen_ff, "zero switch disarmed while released")
   `SPS_ASSERT_IMPLIES(a_end_disarm, clock, reset, !end_armed_ff, end_seen_ff, "end switch disarmed while released")

endmodule

// File: rtl/stepper_phase_sequencer_top.sv
// Stepper phase sequencer top level: request and result registers, control registers.
// Depends on sps_pkg and sps_core.
`timescale 1ns / 1ps

// Takes one request (tick or command) per clock while req_stall is low and returns
// one result per request. Each request is held in an input register until the
// result register is free; there the core updates the motor state and the result
// register captures the new coil pattern, switch flags, remaining steps and step
// total, and rsp_valid rises. The throughput of one request per cycle, while
// rsp_stall does not hold the result, is set by the single-pass state update in the
// core. csr_ready is always high; write the step interval and the half-step mode
// only while no request is in flight.
module stepper_phase_sequencer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sps_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sps_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sps_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sps_pkg::INTERVAL_WIDTH-1:0]   csr_wdata
);

   logic             in_valid_ff, in_valid_in;
   sps_pkg::req_type in_req_ff;
   logic             out_valid_ff, out_valid_in;
   sps_pkg::rsp_type out_rsp_ff;
   sps_pkg::cfg_type cfg_ff;
   sps_pkg::rsp_type core_result;
   logic             advance;

   // Move the held request into the result register when that slot is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_req_ff <= req_payload;
      end
      if (advance) begin
         out_rsp_ff <= core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_interval_ticks <= sps_pkg::INTERVAL_RESET;
         cfg_ff.half_step_mode      <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (sps_pkg::csr_index_type'(csr_index))
            sps_pkg::CSR_STEP_INTERVAL: cfg_ff.step_interval_ticks <= csr_wdata;
            sps_pkg::CSR_HALF_STEP:     cfg_ff.half_step_mode      <= csr_wdata[0];
         endcase
      end
   end

   sps_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_req_ff),
      .cfg     (cfg_ff),
      .result  (core_result)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

endmodule
